// ----- src/gtg_pkg.sv -----
// Package for the go-to-goal proportional controller.
// Holds shared constants, the CORDIC angle table function and the CORDIC vector type.
// No dependencies.
`timescale 1ns / 1ps
package gtg_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int NSTG          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

	// Q3.13 angle constants
	localparam logic signed [17:0] ANG_PI      = 18'sd25736;
	localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
	localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;

	// CORDIC datapath widths: bearing operands are 33 bits, yaw operands up to 34
	localparam int CW = 36;
	localparam int AW = 18;

	// square root: 62-bit radicand, 31 result bits, one bit per stage
	localparam int SQW = 62;
	localparam int SQN = 31;

	// register indexes
	localparam logic [1:0] REG_TOL  = 2'd0;
	localparam logic [1:0] REG_LIN  = 2'd1;
	localparam logic [1:0] REG_ANG  = 2'd2;

	// rounded Q3.13 atan(2^-i)
	function automatic logic signed [AW-1:0] atan_lut(input int i);
		logic signed [AW-1:0] r;
		begin
			unique case (i)
				0: r = 18'sd6434;
				1: r = 18'sd3798;
				2: r = 18'sd2007;
				3: r = 18'sd1019;
				4: r = 18'sd511;
				5: r = 18'sd256;
				6: r = 18'sd128;
				7: r = 18'sd64;
				8: r = 18'sd32;
				9: r = 18'sd16;
				10: r = 18'sd8;
				11: r = 18'sd4;
				12: r = 18'sd2;
				13: r = 18'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// one CORDIC vectoring element carried through the pipe
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
	} cvec_t;

endpackage

// ----- src/gtg_if.sv -----
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload type set at instantiation.
`timescale 1ns / 1ps
interface gtg_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/gtg_types_pkg.sv -----
// Payload types of the controller channels.
// No dependencies.
`timescale 1ns / 1ps
package gtg_types_pkg;
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} pose_t;

	typedef struct packed {
		logic [22:0]        linear_speed;
		logic signed [15:0] angular_speed;
		logic               goal_reached;
	} cmd_t;
endpackage

// ----- src/gtg_cordic_stage.sv -----
// One CORDIC vectoring rotation for both angle paths.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_cordic_stage (
	input  int                          idx,
	input  gtg_pkg::cvec_t              a_in,
	input  gtg_pkg::cvec_t              b_in,
	output gtg_pkg::cvec_t              a_out,
	output gtg_pkg::cvec_t              b_out
);
	import gtg_pkg::*;

	// vectoring step: drive y toward zero
	function automatic cvec_t rot(input cvec_t v, input int i);
		cvec_t r;
		logic signed [CW-1:0] xs, ys;
		begin
			xs = v.x >>> i;
			ys = v.y >>> i;
			if (v.y >= 0) begin
				r.x = v.x + ys;
				r.y = v.y - xs;
				r.z = v.z + atan_lut(i);
			end else begin
				r.x = v.x - ys;
				r.y = v.y + xs;
				r.z = v.z - atan_lut(i);
			end
			return r;
		end
	endfunction

	assign a_out = rot(a_in, idx);
	assign b_out = rot(b_in, idx);
endmodule

// ----- src/go_to_goal_p_controller.sv -----
// Top level of the go-to-goal proportional controller.
// Depends on gtg_pkg, gtg_types_pkg, gtg_if and gtg_cordic_stage.
//
//   channel  dir  payload                                    transfer
//   pose     in   pos, quaternion, goal                      valid & ready
//   cmd      out  linear_speed, angular_speed, goal_reached  valid & ready
//   apb      in   three limit registers                      psel & penable & pwrite
//
// The 31-stage square root sets the pipeline depth; the CORDIC runs in its
// first NSTG stages. One transfer per cycle sustained while cmd is ready.
// The pipe advances when the last stage is empty or taken, so a stall
// holds every stage and nothing is lost or repeated.
// Reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module go_to_goal_p_controller (
	input  logic        clk,
	input  logic        arst_n,
	gtg_if.sink         pose,
	gtg_if.source       cmd,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gtg_pkg::*;
	import gtg_types_pkg::*;

	localparam int DEPTH = SQN + 3;

	logic [22:0] tol_q, lin_q;
	logic [14:0] ang_q;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 23'd6554;
			lin_q <= 23'd32768;
			ang_q <= 15'd8192;
		end else if (psel && penable && pwrite) begin
			if (paddr[3:2] == REG_TOL) tol_q <= pwdata[22:0];
			else if (paddr[3:2] == REG_LIN) lin_q <= pwdata[22:0];
			else if (paddr[3:2] == REG_ANG) ang_q <= pwdata[14:0];
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TOL: prdata = {9'd0, tol_q};
			REG_LIN: prdata = {9'd0, lin_q};
			REG_ANG: prdata = {17'd0, ang_q};
			default: prdata = '0;
		endcase
	end

	// global advance
	logic adv;
	logic [DEPTH:0] v_q;
	assign adv = !v_q[DEPTH] || cmd.ready;
	assign pose.ready = adv;

	// stage 1: differences, quaternion products
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] wz_s1, xy_s1, yy_s1, zz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 33'(pose.data.goal_x) - 33'(pose.data.pos_x);
			dy_s1 <= 33'(pose.data.goal_y) - 33'(pose.data.pos_y);
			wz_s1 <= 32'(pose.data.quat_w) * 32'(pose.data.quat_z);
			xy_s1 <= 32'(pose.data.quat_x) * 32'(pose.data.quat_y);
			yy_s1 <= 32'(pose.data.quat_y) * 32'(pose.data.quat_y);
			zz_s1 <= 32'(pose.data.quat_z) * 32'(pose.data.quat_z);
		end
	end

	// stage 2: squares, yaw operands, saturation flag
	logic [63:0] sdx_s2, sdy_s2;
	logic        sat_s2;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [CW-1:0] num_s2, den_s2;
	logic signed [32:0] adx, ady;
	assign adx = dx_s1[32] ? -dx_s1 : dx_s1;
	assign ady = dy_s1[32] ? -dy_s1 : dy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sdx_s2 <= 64'(adx[31:0]) * 64'(adx[31:0]);
			sdy_s2 <= 64'(ady[31:0]) * 64'(ady[31:0]);
			sat_s2 <= (adx >= 33'sd1073741824) || (ady >= 33'sd1073741824);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			num_s2 <= (CW'(wz_s1) + CW'(xy_s1)) <<< 1;
			den_s2 <= (CW'(1) <<< 28) - ((CW'(yy_s1) + CW'(zz_s1)) <<< 1);
		end
	end

	// stage 3: radicand sum, CORDIC pre-rotation
	function automatic cvec_t prerot(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cvec_t r;
		begin
			r.x = x; r.y = y; r.z = '0;
			if (x < 0) begin
				if (y >= 0) begin
					r.x = y; r.y = -x; r.z = ANG_HALF_PI;
				end else begin
					r.x = -y; r.y = x; r.z = -ANG_HALF_PI;
				end
			end
			return r;
		end
	endfunction

	logic [SQW-1:0] rad_s [SQN+1];
	logic [SQW-1:0] res_s [SQN+1];
	logic           sat_p [SQN+1];
	cvec_t          ca [SQN+1];
	cvec_t          cb [SQN+1];
	logic           za [SQN+1];
	logic           zb [SQN+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s[0] <= SQW'(sdx_s2 + sdy_s2);
			res_s[0] <= '0;
			sat_p[0] <= sat_s2;
			ca[0]    <= prerot(CW'(dy_s2), CW'(dx_s2));
			cb[0]    <= prerot(num_s2, den_s2);
			za[0]    <= (dx_s2 == 0) && (dy_s2 == 0);
			zb[0]    <= (num_s2 == 0) && (den_s2 == 0);
		end
	end

	// square-root and CORDIC stages, one bit / one rotation per stage
	for (genvar k = 0; k < SQN; k++) begin : g_stg
		cvec_t na, nb;
		logic [SQW-1:0] bitv, trial;
		assign bitv  = SQW'(1) << (2 * (SQN - 1 - k));
		assign trial = res_s[k] + bitv;
		if (k < NSTG) begin : g_rot
			gtg_cordic_stage u_rot (.idx(k), .a_in(ca[k]), .b_in(cb[k]),
				.a_out(na), .b_out(nb));
		end else begin : g_pass
			assign na = ca[k];
			assign nb = cb[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rad_s[k] >= trial) begin
					rad_s[k+1] <= rad_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + bitv;
				end else begin
					rad_s[k+1] <= rad_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				sat_p[k+1] <= sat_p[k];
				ca[k+1] <= na;
				cb[k+1] <= nb;
				za[k+1] <= za[k];
				zb[k+1] <= zb[k];
			end
		end
	end

	// final stage: wrap, scale, clamp, select
	logic [30:0] span;
	logic signed [AW:0] bear, yaw, err, ang2, lim;
	assign span = sat_p[SQN] ? 31'h40000000 : res_s[SQN][30:0];
	assign bear = za[SQN] ? '0 : (AW+1)'(ca[SQN].z);
	assign yaw  = zb[SQN] ? '0 : (AW+1)'(cb[SQN].z);
	always_comb begin
		err = bear - yaw;
		if (err > (AW+1)'(ANG_PI)) err = err - (AW+1)'(ANG_TWO_PI);
		else if (err < -(AW+1)'(ANG_PI)) err = err + (AW+1)'(ANG_TWO_PI);
		ang2 = err <<< 1;
		lim  = (AW+1)'({1'b0, ang_q});
		if (ang2 > lim) ang2 = lim;
		if (ang2 < -lim) ang2 = -lim;
	end

	cmd_t out_s;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (31'(tol_q) >= span) begin
				out_s <= '{linear_speed: '0, angular_speed: '0, goal_reached: 1'b1};
			end else begin
				out_s.linear_speed <= (span[30:1] > 30'(lin_q)) ? lin_q : span[23:1];
				out_s.angular_speed <= ang2[15:0];
				out_s.goal_reached <= 1'b0;
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[DEPTH-1:0], pose.valid};
	end

	assign cmd.valid = v_q[DEPTH];
	assign cmd.data  = out_s;

	a_reach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.data.goal_reached |-> cmd.data.linear_speed == 0 &&
		cmd.data.angular_speed == 0) else $error("reached with motion");
	a_lin_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> cmd.data.linear_speed <= lin_q) else $error("linear over limit");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q)) else $error("pipe moved in stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[DEPTH] |-> pose.ready) else $error("empty tail but stalled");
endmodule
